>>> rtl/rtas_pkg.sv
// Shared types, control codes and defaults for the text-art stream decoder.
`timescale 1ns / 1ps

package rtas_pkg;

  // Output coordinate width and colour width
  localparam int CELL_COORD_WIDTH    = 16;
  localparam int RGB_WIDTH           = 24;
  localparam int COORD_WIDTH_DEFAULT = 16;

  // Columns per row after reset
  localparam logic [15:0] LINE_WIDTH_RESET = 16'd80;

  // Control codes in the byte stream
  localparam logic [7:0] CODE_CURSOR = 8'd1;
  localparam logic [7:0] CODE_FORE   = 8'd2;
  localparam logic [7:0] CODE_BACK   = 8'd4;
  localparam logic [7:0] CODE_BOTH   = 8'd6;

  // One emitted character cell
  typedef struct packed {
    logic [CELL_COORD_WIDTH-1:0] column;
    logic [CELL_COORD_WIDTH-1:0] row;
    logic [7:0]                  glyph;
    logic [RGB_WIDTH-1:0]        fore;
    logic [RGB_WIDTH-1:0]        back;
  } cell_t;

  // True for a byte that is a control code and never shows as a cell
  function automatic logic glyph_is_code(input logic [7:0] g);
    return (g == CODE_CURSOR) || (g == CODE_FORE) || (g == CODE_BACK) || (g == CODE_BOTH);
  endfunction

endpackage

>>> rtl/rtas_parser.sv
// Byte parser: cursor, colours and parse phase, one byte per beat.
`timescale 1ns / 1ps

module rtas_parser #(
  parameter int COORD_WIDTH = rtas_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    line_width,
  output logic           emit,
  output rtas_pkg::cell_t cell_data
);
  import rtas_pkg::*;

  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0_0000_0000_0001,
    PH_WORD   = 13'b0_0000_0000_0010,
    PH_CHAR2  = 13'b0_0000_0000_0100,
    PH_SKIP2  = 13'b0_0000_0000_1000,
    PH_FG2    = 13'b0_0000_0001_0000,
    PH_CHAR4  = 13'b0_0000_0010_0000,
    PH_SKIP4  = 13'b0_0000_0100_0000,
    PH_BG4    = 13'b0_0000_1000_0000,
    PH_CHAR6  = 13'b0_0001_0000_0000,
    PH_SKIP6A = 13'b0_0010_0000_0000,
    PH_FG6    = 13'b0_0100_0000_0000,
    PH_SKIP6B = 13'b0_1000_0000_0000,
    PH_BG6    = 13'b1_0000_0000_0000
  } phase_t;

  localparam logic [COORD_WIDTH-1:0] COORD_ONE = {{(COORD_WIDTH-1){1'b0}}, 1'b1};

  phase_t                 phase, phase_next;
  logic [2:0]             byte_count, byte_count_next;
  logic [COORD_WIDTH-1:0] column, column_next;
  logic [COORD_WIDTH-1:0] row, row_next;
  logic [RGB_WIDTH-1:0]   fore, fore_next;
  logic [RGB_WIDTH-1:0]   back, back_next;
  logic [7:0]             held, held_next;
  logic [COORD_WIDTH-1:0] gather, gather_next;

  logic [COORD_WIDTH-1:0] column_base;
  logic [COORD_WIDTH+7:0] gather_wide;
  logic [COORD_WIDTH+15:0] column_wide;
  logic [COORD_WIDTH+15:0] width_wide;
  logic [COORD_WIDTH+15:0] cell_column_wide;
  logic [COORD_WIDTH+15:0] cell_row_wide;
  logic                   wrap;
  logic                   emit_try;
  logic [7:0]             emit_glyph;

  // Compare cursor and width at a common width
  assign column_wide = {16'b0, column};
  assign width_wide  = {{COORD_WIDTH{1'b0}}, line_width};
  assign wrap        = (column_wide == width_wide);
  assign gather_wide = {gather, data_byte};

  // Next state for the byte on the input
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    column_next     = column;
    row_next        = row;
    fore_next       = fore;
    back_next       = back;
    held_next       = held;
    gather_next     = gather;
    column_base     = column;
    emit_try        = 1'b0;
    emit_glyph      = data_byte;
    emit            = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        byte_count_next = 3'd0;
        if (wrap) begin
          column_base = '0;
          row_next    = row + COORD_ONE;
        end
        column_next = column_base;
        case (data_byte)
          CODE_CURSOR: phase_next = PH_WORD;
          CODE_FORE:   phase_next = PH_CHAR2;
          CODE_BACK:   phase_next = PH_CHAR4;
          CODE_BOTH:   phase_next = PH_CHAR6;
          default:     emit_try   = 1'b1;
        endcase
      end
      PH_WORD: begin
        // Gather big-endian words: row after four bytes, column after eight
        gather_next     = gather_wide[COORD_WIDTH-1:0];
        byte_count_next = byte_count + 3'd1;
        if (byte_count == 3'd3) begin
          row_next = gather_wide[COORD_WIDTH-1:0];
        end else if (byte_count == 3'd7) begin
          column_next     = gather_wide[COORD_WIDTH-1:0];
          phase_next      = PH_IDLE;
          byte_count_next = 3'd0;
        end
      end
      PH_CHAR2: begin
        held_next  = data_byte;
        phase_next = PH_SKIP2;
      end
      PH_SKIP2: begin
        phase_next      = PH_FG2;
        byte_count_next = 3'd0;
      end
      PH_FG2: begin
        fore_next = {fore[RGB_WIDTH-9:0], data_byte};
        if (byte_count < 3'd2) begin
          byte_count_next = byte_count + 3'd1;
        end else begin
          byte_count_next = 3'd0;
          emit_glyph      = held;
          if (held == CODE_BACK) begin
            phase_next = PH_CHAR4;
          end else if (held == CODE_BOTH) begin
            phase_next = PH_CHAR6;
          end else begin
            emit_try = 1'b1;
          end
        end
      end
      PH_CHAR4: begin
        held_next  = data_byte;
        phase_next = PH_SKIP4;
      end
      PH_SKIP4: begin
        phase_next      = PH_BG4;
        byte_count_next = 3'd0;
      end
      PH_BG4: begin
        back_next = {back[RGB_WIDTH-9:0], data_byte};
        if (byte_count < 3'd2) begin
          byte_count_next = byte_count + 3'd1;
        end else begin
          byte_count_next = 3'd0;
          emit_glyph      = held;
          if (held == CODE_BOTH) begin
            phase_next = PH_CHAR6;
          end else begin
            emit_try = 1'b1;
          end
        end
      end
      PH_CHAR6: begin
        held_next  = data_byte;
        phase_next = PH_SKIP6A;
      end
      PH_SKIP6A: begin
        phase_next      = PH_FG6;
        byte_count_next = 3'd0;
      end
      PH_FG6: begin
        fore_next = {fore[RGB_WIDTH-9:0], data_byte};
        if (byte_count < 3'd2) begin
          byte_count_next = byte_count + 3'd1;
        end else begin
          byte_count_next = 3'd0;
          phase_next      = PH_SKIP6B;
        end
      end
      PH_SKIP6B: begin
        phase_next      = PH_BG6;
        byte_count_next = 3'd0;
      end
      PH_BG6: begin
        back_next = {back[RGB_WIDTH-9:0], data_byte};
        if (byte_count < 3'd2) begin
          byte_count_next = byte_count + 3'd1;
        end else begin
          byte_count_next = 3'd0;
          emit_glyph      = held;
          emit_try        = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        byte_count_next = 3'd0;
      end
    endcase

    // End of a sequence: back to idle, show the glyph unless it is a code
    if (emit_try) begin
      phase_next      = PH_IDLE;
      byte_count_next = 3'd0;
      if (!glyph_is_code(emit_glyph)) begin
        emit        = accept;
        column_next = column_base + COORD_ONE;
      end
    end
  end

  // Build the cell from the cursor before the advance and the fresh colours
  assign cell_column_wide = {16'b0, column_base};
  assign cell_row_wide    = {16'b0, row_next};
  assign cell_data.column = cell_column_wide[CELL_COORD_WIDTH-1:0];
  assign cell_data.row    = cell_row_wide[CELL_COORD_WIDTH-1:0];
  assign cell_data.glyph  = emit_glyph;
  assign cell_data.fore   = fore_next;
  assign cell_data.back   = back_next;

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= 3'd0;
      column     <= '0;
      row        <= '0;
      fore       <= '0;
      back       <= '0;
      held       <= 8'd0;
      gather     <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      column     <= column_next;
      row        <= row_next;
      fore       <= fore_next;
      back       <= back_next;
      held       <= held_next;
      gather     <= gather_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_accept: assert property (@(posedge clk) disable iff (rst)
    emit |-> accept)
    else $error("cell emitted without an accepted beat");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == PH_IDLE) && (byte_count == 3'd0))
    else $error("parser not idle after emitting a cell");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) || (phase == PH_CHAR2) || (phase == PH_SKIP2) ||
    (phase == PH_CHAR4) || (phase == PH_SKIP4) || (phase == PH_CHAR6) ||
    (phase == PH_SKIP6A) || (phase == PH_SKIP6B) |-> byte_count == 3'd0)
    else $error("byte count set outside a counting phase");

  a_colour_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FG2) || (phase == PH_BG4) || (phase == PH_FG6) ||
    (phase == PH_BG6) |-> byte_count <= 3'd2)
    else $error("colour byte count beyond three bytes");
`endif

endmodule

>>> rtl/rtas_skid.sv
// Result register with a skid stage between parser and output channel.
`timescale 1ns / 1ps

module rtas_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtas_pkg::cell_t cell_in,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output rtas_pkg::cell_t cell_out
);
  import rtas_pkg::*;

  logic  skid_valid;
  cell_t skid_cell;
  logic  out_take;

  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // Control: main register first, skid stage when the main one is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: move the skid beat forward, or load the fresh one
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        cell_out <= skid_cell;
      end
    end else if (push) begin
      if (out_valid && !out_take) begin
        skid_cell <= cell_in;
      end else begin
        cell_out <= cell_in;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("beat pushed into a full skid stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_take |=> !skid_valid && out_valid)
    else $error("skid beat not moved to the result register");
`endif

endmodule

>>> rtl/rgb_text_art_stream_decoder.sv
// Top level of the truecolour text-art stream decoder.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_stall  | data_byte
//   output   | out_valid / out_stall| cell_column, cell_row, glyph_code, fore_rgb,
//            |                      | back_rgb
//   config   | cfg_wr_en            | cfg_wr_data (line_width)
//
// One input beat per cycle while in_stall is low; each byte updates the parser
// registers in the cycle it is accepted, and a cell it completes is registered.
// A two-entry result stage (register plus skid) lets input flow while a cell
// waits; in_stall rises only when both entries are full.
// Synchronous reset returns the parser to idle, cursor and colours to zero
// and line_width to 80.
`timescale 1ns / 1ps

module rgb_text_art_stream_decoder #(
  parameter int COORD_WIDTH = rtas_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] cell_column,
  output logic [15:0] cell_row,
  output logic [7:0]  glyph_code,
  output logic [23:0] fore_rgb,
  output logic [23:0] back_rgb,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import rtas_pkg::*;

  logic [15:0] line_width;
  logic        accept;
  logic        emit;
  cell_t       cell_new;
  cell_t       cell_out;

  // Hold the line width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  assign accept = in_valid && !in_stall;

  rtas_parser #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .line_width(line_width),
    .emit      (emit),
    .cell_data (cell_new)
  );

  rtas_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (emit),
    .cell_in  (cell_new),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_out (cell_out)
  );

  // Unpack the cell onto the output fields
  assign cell_column = cell_out.column;
  assign cell_row    = cell_out.row;
  assign glyph_code  = cell_out.glyph;
  assign fore_rgb    = cell_out.fore;
  assign back_rgb    = cell_out.back;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the text-art stream decoder: random byte streams against a cell predictor.
`timescale 1ns / 1ps

module tb;
  import rtas_pkg::*;

  localparam int QUIET_LIMIT = 200;

  // Parser phases of the predictor
  typedef enum logic [3:0] {
    P_IDLE, P_COORD,
    P_FG_CHAR, P_FG_PAD, P_FG_RGB,
    P_BG_CHAR, P_BG_PAD, P_BG_RGB,
    P_BOTH_CHAR, P_BOTH_PAD_FG, P_BOTH_FG, P_BOTH_PAD_BG, P_BOTH_BG
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] cell_column;
  logic [15:0] cell_row;
  logic [7:0]  glyph_code;
  logic [23:0] fore_rgb;
  logic [23:0] back_rgb;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // Body bytes still to send and cells still to arrive
  logic [7:0] body_bytes [$];
  cell_t      cells_due [$];

  // Predictor state
  logic [15:0]  line_w    = LINE_WIDTH_RESET;
  parse_phase_e parse_st  = P_IDLE;
  logic [2:0]   step_cnt  = '0;
  logic [15:0]  cur_col   = '0;
  logic [15:0]  cur_row   = '0;
  logic [23:0]  fg_rgb    = '0;
  logic [23:0]  bg_rgb    = '0;
  logic [7:0]   held_char = '0;
  logic [15:0]  coord_acc = '0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  bit   in_burst = 1'b0;
  int   out_hold = 0;
  bit   out_burst = 1'b0;
  int   mismatches = 0;
  int   quiet = 0;

  rgb_text_art_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_column(cell_column),
    .cell_row   (cell_row),
    .glyph_code (glyph_code),
    .fore_rgb   (fore_rgb),
    .back_rgb   (back_rgb),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic bit is_code(input logic [7:0] g);
    return (g == CODE_CURSOR) || (g == CODE_FORE) || (g == CODE_BACK) || (g == CODE_BOTH);
  endfunction

  // Close a colour sequence or a top-level byte: show the glyph unless it is a code
  task automatic emit_glyph(input logic [7:0] g);
    cell_t c;
    parse_st = P_IDLE;
    step_cnt = '0;
    if (!is_code(g)) begin
      c.column = cur_col;
      c.row    = cur_row;
      c.glyph  = g;
      c.fore   = fg_rgb;
      c.back   = bg_rgb;
      cells_due.push_back(c);
      cur_col = cur_col + 16'd1;
    end
  endtask

  // Advance the parser by one accepted byte and queue any cell it shows
  task automatic decode_byte(input logic [7:0] b);
    case (parse_st)
      P_IDLE: begin
        if (cur_col == line_w) begin
          cur_col = '0;
          cur_row = cur_row + 16'd1;
        end
        step_cnt = '0;
        if (b == CODE_CURSOR) begin
          parse_st  = P_COORD;
          coord_acc = '0;
        end else if (b == CODE_FORE) begin
          parse_st = P_FG_CHAR;
        end else if (b == CODE_BACK) begin
          parse_st = P_BG_CHAR;
        end else if (b == CODE_BOTH) begin
          parse_st = P_BOTH_CHAR;
        end else begin
          emit_glyph(b);
        end
      end
      P_COORD: begin
        coord_acc = {coord_acc[7:0], b};
        if (step_cnt == 3'd3) begin
          cur_row   = coord_acc;
          coord_acc = '0;
          step_cnt  = step_cnt + 3'd1;
        end else if (step_cnt == 3'd7) begin
          cur_col   = coord_acc;
          coord_acc = '0;
          parse_st  = P_IDLE;
          step_cnt  = '0;
        end else begin
          step_cnt = step_cnt + 3'd1;
        end
      end
      P_FG_CHAR: begin
        held_char = b;
        parse_st  = P_FG_PAD;
      end
      P_FG_PAD: begin
        parse_st = P_FG_RGB;
        step_cnt = '0;
      end
      P_FG_RGB: begin
        fg_rgb = {fg_rgb[15:0], b};
        if (step_cnt < 3'd2) begin
          step_cnt = step_cnt + 3'd1;
        end else begin
          step_cnt = '0;
          if (held_char == CODE_BACK) parse_st = P_BG_CHAR;
          else if (held_char == CODE_BOTH) parse_st = P_BOTH_CHAR;
          else emit_glyph(held_char);
        end
      end
      P_BG_CHAR: begin
        held_char = b;
        parse_st  = P_BG_PAD;
      end
      P_BG_PAD: begin
        parse_st = P_BG_RGB;
        step_cnt = '0;
      end
      P_BG_RGB: begin
        bg_rgb = {bg_rgb[15:0], b};
        if (step_cnt < 3'd2) begin
          step_cnt = step_cnt + 3'd1;
        end else begin
          step_cnt = '0;
          if (held_char == CODE_BOTH) parse_st = P_BOTH_CHAR;
          else emit_glyph(held_char);
        end
      end
      P_BOTH_CHAR: begin
        held_char = b;
        parse_st  = P_BOTH_PAD_FG;
      end
      P_BOTH_PAD_FG: begin
        parse_st = P_BOTH_FG;
        step_cnt = '0;
      end
      P_BOTH_FG: begin
        fg_rgb = {fg_rgb[15:0], b};
        if (step_cnt < 3'd2) begin
          step_cnt = step_cnt + 3'd1;
        end else begin
          step_cnt = '0;
          parse_st = P_BOTH_PAD_BG;
        end
      end
      P_BOTH_PAD_BG: begin
        parse_st = P_BOTH_BG;
        step_cnt = '0;
      end
      P_BOTH_BG: begin
        bg_rgb = {bg_rgb[15:0], b};
        if (step_cnt < 3'd2) begin
          step_cnt = step_cnt + 3'd1;
        end else begin
          step_cnt = '0;
          emit_glyph(held_char);
        end
      end
      default: begin
        parse_st = P_IDLE;
        step_cnt = '0;
      end
    endcase
  endtask

  // Stream building blocks
  function automatic logic [7:0] plain_glyph();
    logic [7:0] g;
    g = 8'($urandom_range(0, 255));
    if (is_code(g)) g = g ^ 8'h80;
    return g;
  endfunction

  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(0, 9))
      0: return CODE_BACK;
      1: return CODE_BOTH;
      2: return ($urandom_range(0, 1) != 0) ? CODE_CURSOR : CODE_FORE;
      default: return plain_glyph();
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    int lim;
    lim = (int'(line_w) + 2 > 65535) ? 65535 : int'(line_w) + 2;
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, lim));
      1: return 16'hFFFF - 16'($urandom_range(0, 15));
      2: return line_w - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_word(input logic [15:0] low);
    body_bytes.push_back(8'($urandom_range(0, 255)));
    body_bytes.push_back(8'($urandom_range(0, 255)));
    body_bytes.push_back(low[15:8]);
    body_bytes.push_back(low[7:0]);
  endtask

  task automatic push_rgb();
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0: body_bytes.push_back(8'h00);
        1: body_bytes.push_back(8'hFF);
        default: body_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Colour sequence body; a code glyph that chains opens the next body
  task automatic push_colour_body(input logic [7:0] code);
    logic [7:0] kind;
    logic [7:0] g;
    kind = code;
    while (kind != 8'h00) begin
      g = pick_glyph();
      body_bytes.push_back(g);
      body_bytes.push_back(8'($urandom_range(0, 255)));
      if (kind == CODE_BOTH) begin
        push_rgb();
        body_bytes.push_back(8'($urandom_range(0, 255)));
      end
      push_rgb();
      if ((kind == CODE_FORE && (g == CODE_BACK || g == CODE_BOTH)) ||
          (kind == CODE_BACK && g == CODE_BOTH))
        kind = g;
      else
        kind = 8'h00;
    end
  endtask

  // Mostly well-formed sequences, with stray bytes and cut-off sequences mixed in
  task automatic push_random_stream(input int n);
    int start;
    int cut;
    start = body_bytes.size();
    while (body_bytes.size() - start < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: body_bytes.push_back(plain_glyph());
        8, 9: begin
          body_bytes.push_back(CODE_CURSOR);
          push_word(pick_coord());
          push_word(pick_coord());
        end
        10, 11: begin
          body_bytes.push_back(CODE_FORE);
          push_colour_body(CODE_FORE);
        end
        12, 13: begin
          body_bytes.push_back(CODE_BACK);
          push_colour_body(CODE_BACK);
        end
        14, 15: begin
          body_bytes.push_back(CODE_BOTH);
          push_colour_body(CODE_BOTH);
        end
        16, 17: body_bytes.push_back(8'($urandom_range(0, 255)));
        default: begin
          body_bytes.push_back(pick_glyph());
          cut = $urandom_range(1, 5);
          for (int i = 0; i < cut; i++) body_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Hold until every byte is taken and every cell has come out
  task automatic wait_drain();
    while (body_bytes.size() != 0 || in_valid) @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [15:0] w);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    line_w = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input beat taken: run the predictor
  always @(posedge clk) begin
    in_taken <= 1'b0;
    if (!rst && in_valid && !in_stall) begin
      in_taken <= 1'b1;
      decode_byte(data_byte);
    end
  end

  // Driver: present the next byte after a random gap, hold while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (body_bytes.size() != 0) begin
        data_byte <= body_bytes.pop_front();
        in_valid  <= 1'b1;
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output beat with the oldest predicted cell
  always @(posedge clk) begin
    cell_t want;
    out_taken <= 1'b0;
    if (!rst && out_valid && !out_stall) begin
      out_taken <= 1'b1;
      if (cells_due.size() == 0) begin
        $error("unexpected cell: column %0h row %0h glyph %0h",
               cell_column, cell_row, glyph_code);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        check_field("cell_column", 24'(want.column), 24'(cell_column));
        check_field("cell_row", 24'(want.row), 24'(cell_row));
        check_field("glyph_code", 24'(want.glyph), 24'(glyph_code));
        check_field("fore_rgb", want.fore, fore_rgb);
        check_field("back_rgb", want.back, back_rgb);
      end
    end
  end

  // Receiver back-pressure: a random stall ahead of each cell
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 6);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [15:0] w;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cursor at the last row and column, wrap of the column, chained colours,
    // a code as the glyph of a colour sequence; all at the reset line width
    body_bytes = '{CODE_CURSOR, 8'h12, 8'h34, 8'hFF, 8'hFF, 8'hAB, 8'hCD, 8'hFF, 8'hFF,
                   8'h00, 8'hFF,
                   CODE_FORE, CODE_BACK, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                   8'h7A, 8'h00, 8'h01, 8'h02, 8'h03,
                   CODE_BOTH, CODE_CURSOR, 8'h55, 8'h00, 8'h00, 8'h00,
                   8'hAA, 8'h80, 8'h80, 8'h80};
    wait_drain();

    // Random stretches over a range of line widths, the extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: w = 16'd1;
        1: w = 16'd65535;
        2: w = 16'd0;
        3: w = 16'd7;
        4: w = 16'($urandom_range(2, 300));
        5: w = 16'd3;
        default: w = 16'd80;
      endcase
      set_line_width(w);
      push_random_stream(225);
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
